// ===== design/vertex_rotate_project_defines.svh =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_defines
// Assertion macros shared by the vertex rotate and project block.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

`ifndef SYNTH
`define VRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex_rotate_project check failed");
`define VRP_ASSERT_NEXT_NR(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vertex_rotate_project check failed");
`else
`define VRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`define VRP_ASSERT_NEXT_NR(label, clk, ante, cons)
`endif

`endif

// ===== design/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Types, register indexes and constant tables for the vertex rotate block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vrp_pkg;

   localparam int HALF_SIZE_DEFAULT = 4096;
   localparam int VIEW_SIZE_DEFAULT = 160;

   localparam int CW = 16;   // coordinate width
   localparam int MW = 20;   // intermediate rotation width

   localparam logic [2:0] REG_ANGLE_X     = 3'd0;
   localparam logic [2:0] REG_ANGLE_Y     = 3'd1;
   localparam logic [2:0] REG_ANGLE_Z     = 3'd2;
   localparam logic [2:0] REG_ZOOM_STEP   = 3'd3;
   localparam logic [2:0] REG_PERSPECTIVE = 3'd4;

   typedef struct packed {
      logic signed [15:0] sin_x;
      logic signed [15:0] cos_x;
      logic signed [15:0] sin_y;
      logic signed [15:0] cos_y;
      logic signed [15:0] sin_z;
      logic signed [15:0] cos_z;
   } trig_type;

   typedef logic [255:0][15:0] sin_table_type;
   typedef logic [255:0][11:0] factor_table_type;

   function automatic logic [15:0] poly_sin(input logic [31:0] phase);
      logic [31:0] u;
      logic [31:0] y;
      logic        neg;
      u = (phase << 1) & 32'h0000_FFFF;
      neg = u[15];
      if (u[14]) begin
         u = (32'h0000_8000 - u) & 32'h0000_FFFF;
      end
      u = (u & 32'h0000_7FFF) >> 1;
      y = (32'd292421 * u) >> 13;
      y = 32'd2746362156 - ((u * y) >> 3);
      y = u * (y >> 13);
      y = u * (y >> 13);
      y = 32'd3370945099 - (y >> 1);
      y = u * (y >> 13);
      y = (y + 32'h0004_0000) >> 19;
      if (neg) begin
         y = 32'd0 - y;
      end
      return y[15:0];
   endfunction

   function automatic sin_table_type build_sin_table();
      sin_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = poly_sin(32'(i) * 32'd128);
      end
      return t;
   endfunction

   // shift-subtract quotient of 65536 by d
   function automatic logic [11:0] recip_65536(input int d);
      int q;
      int r;
      q = 0;
      r = 65536;
      for (int b = 16; b >= 0; b--) begin
         if ((d << b) <= r) begin
            r = r - (d << b);
            q = q + (1 << b);
         end
      end
      return 12'(q);
   endfunction

   // index is depth/2 modulo 256; zero stands for 256
   function automatic factor_table_type build_factor_table();
      factor_table_type t;
      for (int i = 0; i < 256; i++) begin
         if (i == 0) begin
            t[i] = 12'd256;
         end else if (i < 32) begin
            t[i] = 12'd0;
         end else begin
            t[i] = recip_65536(i);
         end
      end
      return t;
   endfunction

   localparam sin_table_type    SIN_TABLE    = build_sin_table();
   localparam factor_table_type FACTOR_TABLE = build_factor_table();

endpackage
`default_nettype wire

// ===== design/vrp_csr.sv =====
// ----------------------------------------------------------------------------
// vrp_csr
// Configuration registers; looks up sine and cosine on each angle write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrp_csr
   import vrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_data,
   output trig_type        trig,
   output logic [2:0]      zoom_step,
   output logic            perspective_on
);

   trig_type   trig_ff, trig_in;
   logic [2:0] zoom_ff, zoom_in;
   logic       persp_ff, persp_in;
   logic [7:0] cos_idx;

   assign cos_idx = csr_data + 8'd64;

   always_comb begin
      trig_in = trig_ff;
      zoom_in = zoom_ff;
      persp_in = persp_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ANGLE_X: begin
               trig_in.sin_x = SIN_TABLE[csr_data];
               trig_in.cos_x = SIN_TABLE[cos_idx];
            end
            REG_ANGLE_Y: begin
               trig_in.sin_y = SIN_TABLE[csr_data];
               trig_in.cos_y = SIN_TABLE[cos_idx];
            end
            REG_ANGLE_Z: begin
               trig_in.sin_z = SIN_TABLE[csr_data];
               trig_in.cos_z = SIN_TABLE[cos_idx];
            end
            REG_ZOOM_STEP:   zoom_in = csr_data[2:0];
            REG_PERSPECTIVE: persp_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff <= '{sin_x: 16'sd0, cos_x: 16'sd4096, sin_y: 16'sd0,
                      cos_y: 16'sd4096, sin_z: 16'sd0, cos_z: 16'sd4096};
         zoom_ff <= 3'd0;
         persp_ff <= 1'b1;
      end else begin
         trig_ff <= trig_in;
         zoom_ff <= zoom_in;
         persp_ff <= persp_in;
      end
   end

   assign trig = trig_ff;
   assign zoom_step = zoom_ff;
   assign perspective_on = persp_ff;

endmodule
`default_nettype wire

// ===== design/vrp_rotate.sv =====
// ----------------------------------------------------------------------------
// vrp_rotate
// Three-stage rotation of one point about Y, then X, then Z.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrp_rotate
   import vrp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [2:0]            en,
   input  trig_type                   trig,
   input  wire logic signed [CW-1:0]  in_x,
   input  wire logic signed [CW-1:0]  in_y,
   input  wire logic signed [CW-1:0]  in_z,
   output logic signed [CW-1:0]       out_x,
   output logic signed [CW-1:0]       out_y,
   output logic signed [CW-1:0]       out_z
);

   logic signed [32:0]   s1_rx, s1_rz;
   logic signed [MW-1:0] rx1_ff, rx1_in, rz1_ff, rz1_in;
   logic signed [CW-1:0] y1_ff;
   logic signed [36:0]   s2_ry, s2_rz;
   logic signed [MW-1:0] rx2_ff, ry2_ff, ry2_in, rz2_ff, rz2_in;
   logic signed [36:0]   s3_x, s3_y;
   logic signed [CW-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff;

   always_comb begin
      s1_rx = 33'(in_x * trig.cos_y) + 33'(in_z * trig.sin_y);
      s1_rz = 33'(in_z * trig.cos_y) - 33'(in_x * trig.sin_y);
      rx1_in = s1_rx[MW+11:12];
      rz1_in = s1_rz[MW+11:12];
      s2_ry = 37'(y1_ff * trig.cos_x) - 37'(rz1_ff * trig.sin_x);
      s2_rz = 37'(y1_ff * trig.sin_x) + 37'(rz1_ff * trig.cos_x);
      ry2_in = s2_ry[MW+11:12];
      rz2_in = s2_rz[MW+11:12];
      s3_x = 37'(rx2_ff * trig.cos_z) - 37'(ry2_ff * trig.sin_z);
      s3_y = 37'(rx2_ff * trig.sin_z) + 37'(ry2_ff * trig.cos_z);
      ox_in = s3_x[CW+11:12];
      oy_in = s3_y[CW+11:12];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rx1_ff <= rx1_in;
         rz1_ff <= rz1_in;
         y1_ff <= in_y;
      end
      if (en[1]) begin
         rx2_ff <= rx1_ff;
         ry2_ff <= ry2_in;
         rz2_ff <= rz2_in;
      end
      if (en[2]) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         oz_ff <= rz2_ff[CW-1:0];
      end
   end

   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;

endmodule
`default_nettype wire

// ===== design/vrp_project.sv =====
// ----------------------------------------------------------------------------
// vrp_project
// Zoom and sum, depth clamp with reciprocal lookup, perspective and centering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrp_project
   import vrp_pkg::*;
#(
   parameter int VIEW_SIZE = VIEW_SIZE_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic [2:0]           en,
   input  wire logic [2:0]           zoom_step,
   input  wire logic                 perspective_on,
   input  wire logic signed [CW-1:0] vert_x,
   input  wire logic signed [CW-1:0] vert_y,
   input  wire logic signed [CW-1:0] vert_z,
   input  wire logic signed [CW-1:0] cen_x,
   input  wire logic signed [CW-1:0] cen_y,
   input  wire logic signed [CW-1:0] cen_z,
   output logic signed [CW-1:0]      screen_x,
   output logic signed [CW-1:0]      screen_y
);

   localparam logic signed [CW-1:0] HALF_VIEW = CW'(VIEW_SIZE >> 1);

   logic [10:0]          zoom;
   logic signed [11:0]   zoom_s;
   logic signed [27:0]   pvx, pvy, pvz, pcx, pcy, pcz;
   logic signed [CW-1:0] v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic signed [CW-1:0] dz, dz_c;
   logic [8:0]           zi;
   logic [11:0]          fac_ff;
   logic signed [CW-1:0] w0_ff, w1_ff;
   logic signed [28:0]   px, py;
   logic signed [CW-1:0] sx_in, sy_in, sx_ff, sy_ff;

   function automatic logic signed [CW-1:0] zscale(input logic signed [27:0] p);
      return {{(CW-9){p[27]}}, p[27:19]};
   endfunction

   always_comb begin
      zoom = 11'd1024 - {1'b0, zoom_step, 7'd0};
      zoom_s = signed'({1'b0, zoom});
      pvx = vert_x * zoom_s;
      pvy = vert_y * zoom_s;
      pvz = vert_z * zoom_s;
      pcx = cen_x * zoom_s;
      pcy = cen_y * zoom_s;
      pcz = cen_z * zoom_s;
      v0_in = zscale(pvx) + zscale(pcx);
      v1_in = zscale(pvy) + zscale(pcy);
      v2_in = zscale(pvz) + zscale(pcz);

      dz = v2_ff + 16'sd128;
      if (dz < 16'sd64) begin
         dz_c = 16'sd64;
      end else if (dz > 16'sd512) begin
         dz_c = 16'sd512;
      end else begin
         dz_c = dz;
      end
      zi = dz_c[9:1];

      px = w0_ff * signed'({1'b0, fac_ff});
      py = w1_ff * signed'({1'b0, fac_ff});
      sx_in = (perspective_on ? px[CW+8:9] : w0_ff) + HALF_VIEW;
      sy_in = (perspective_on ? py[CW+8:9] : w1_ff) + HALF_VIEW;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (en[1]) begin
         w0_ff <= v0_ff;
         w1_ff <= v1_ff;
         fac_ff <= FACTOR_TABLE[zi[7:0]];
      end
      if (en[2]) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
   end

   assign screen_x = sx_ff;
   assign screen_y = sy_ff;

endmodule
`default_nettype wire

// ===== design/vertex_rotate_project.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Rotates a cube corner and block center, zooms, and projects to the screen.
// ----------------------------------------------------------------------------
// channel  direction  payload
// req      in         corner, offset_x, offset_y, offset_z
// rsp      out        screen_x, screen_y
// csr      in         register index, write data
//
// Seven register stages: one input stage, three rotation stages, zoom-sum,
// depth/reciprocal lookup, perspective multiply into the output register.
// Accepts one request per cycle unless a stalled response backs up the pipeline.
// Each stage advances when empty or when the stage after it advances, so a
// stalled response holds only the stages behind it that are full.
// Synchronous reset clears the valid bits and loads sin 0, cos 4096.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_rotate_project_defines.svh"
module vertex_rotate_project
   import vrp_pkg::*;
#(
   parameter int HALF_SIZE = HALF_SIZE_DEFAULT,
   parameter int VIEW_SIZE = VIEW_SIZE_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // corner, offset_x, offset_y, offset_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // screen_x, screen_y
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   localparam int NSTG = 7;
   localparam logic signed [CW-1:0] HS = CW'(HALF_SIZE);
   localparam logic signed [CW-1:0] FS = CW'(2 * HALF_SIZE);

   trig_type             trig;
   logic [2:0]           zoom_step;
   logic                 perspective_on;
   logic [NSTG-1:0]      valid_ff, valid_in, en;
   logic [2:0]           corner;
   logic signed [2:0]    off_x, off_y, off_z;
   logic signed [CW-1:0] vx_ff, vy_ff, vz_ff, cx_ff, cy_ff, cz_ff;
   logic signed [CW-1:0] vx_in, vy_in, vz_in;
   logic signed [CW-1:0] rvx, rvy, rvz, rcx, rcy, rcz;
   logic signed [CW-1:0] screen_x, screen_y;

   assign csr_ready = 1'b1;

   vrp_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_valid & csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .trig(trig),
      .zoom_step(zoom_step),
      .perspective_on(perspective_on)
   );

   always_comb begin
      en[NSTG-1] = !valid_ff[NSTG-1] || rsp_tready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = req_tvalid;
      for (int i = 1; i < NSTG; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_comb begin
      corner = req_tdata[2:0];
      off_x = req_tdata[5:3];
      off_y = req_tdata[8:6];
      off_z = req_tdata[11:9];
      vx_in = (corner[0] ^ corner[1]) ? HS : -HS;
      vy_in = corner[1] ? HS : -HS;
      vz_in = corner[2] ? HS : -HS;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vz_ff <= vz_in;
         cx_ff <= CW'(off_x * FS);
         cy_ff <= CW'(off_y * FS);
         cz_ff <= CW'(off_z * FS);
      end
   end

   vrp_rotate u_rot_vert (
      .clock(clock), .en(en[3:1]), .trig(trig),
      .in_x(vx_ff), .in_y(vy_ff), .in_z(vz_ff),
      .out_x(rvx), .out_y(rvy), .out_z(rvz)
   );

   vrp_rotate u_rot_cen (
      .clock(clock), .en(en[3:1]), .trig(trig),
      .in_x(cx_ff), .in_y(cy_ff), .in_z(cz_ff),
      .out_x(rcx), .out_y(rcy), .out_z(rcz)
   );

   vrp_project #(.VIEW_SIZE(VIEW_SIZE)) u_project (
      .clock(clock),
      .en(en[6:4]),
      .zoom_step(zoom_step),
      .perspective_on(perspective_on),
      .vert_x(rvx), .vert_y(rvy), .vert_z(rvz),
      .cen_x(rcx), .cen_y(rcy), .cen_z(rcz),
      .screen_x(screen_x),
      .screen_y(screen_y)
   );

   assign rsp_tvalid = valid_ff[NSTG-1];
   assign rsp_tdata = {screen_y, screen_x};

   `VRP_ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, valid_ff[0])
   `VRP_ASSERT_NEXT(a_drain, clock, reset, valid_ff[NSTG-2] && !valid_ff[NSTG-1], rsp_tvalid)
   `VRP_ASSERT_NEXT_NR(a_reset_trig, clock, reset, trig.cos_x == 16'sd4096 && trig.sin_z == 16'sd0)

endmodule
`default_nettype wire
